// ----- rtl/rsh_pkg.sv -----
// shared constants and types for the ray against sphere hit test
`default_nettype none
package rsh_pkg;

  // default coordinate width, signed fixed point
  localparam int COORD_WIDTH_DEF = 24;

  // width of the configuration register index
  localparam int CFG_IDX_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X = 8'd0,
    CFG_CENTER_Y = 8'd1,
    CFG_CENTER_Z = 8'd2,
    CFG_RADIUS   = 8'd3
  } rsh_cfg_idx_t;

  // per-ray decision flags that ride along with the discriminant math
  typedef struct packed {
    logic c_le0;
    logic h_le0;
    logic zero_dir;
  } rsh_tag_t;

endpackage
`default_nettype wire

// ----- rtl/rsh_if.sv -----
// channel interfaces: ray requests, hit results and register writes
`default_nettype none
interface rsh_ray_if #(
  parameter int W = 24
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] origin_x;
  logic signed [W-1:0] origin_y;
  logic signed [W-1:0] origin_z;
  logic signed [W-1:0] dir_x;
  logic signed [W-1:0] dir_y;
  logic signed [W-1:0] dir_z;

  modport source (
    output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    input  ready
  );
  modport sink (
    input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    output ready
  );
endinterface

interface rsh_hit_if;
  logic valid;
  logic ready;
  logic hit;
  logic zero_direction;

  modport source (output valid, hit, zero_direction, input ready);
  modport sink (input valid, hit, zero_direction, output ready);
endinterface

interface rsh_cfg_if #(
  parameter int W = 24
);
  import rsh_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [W-1:0]         wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface
`default_nettype wire

// ----- rtl/rsh_disc.sv -----
// split-multiply discriminant sign: q_ge0 = |h|^2 >= a*c, three stages
`default_nettype none
module rsh_disc #(
  parameter int COORD_WIDTH = rsh_pkg::COORD_WIDTH_DEF
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        s_valid,
  output logic                       s_ready,
  input  wire rsh_pkg::rsh_tag_t     s_tag,
  input  wire [2*COORD_WIDTH+3:0]    s_habs,
  input  wire [2*COORD_WIDTH+3:0]    s_a,
  input  wire [2*COORD_WIDTH+3:0]    s_c,
  output logic                       m_valid,
  input  wire                        m_ready,
  output rsh_pkg::rsh_tag_t          m_tag,
  output logic                       m_q_ge0
);
  import rsh_pkg::*;

  localparam int HW = COORD_WIDTH + 2;  // half operand width
  localparam int MW = 2 * HW;           // operand and partial product width
  localparam int PW = 4 * HW;           // full product width

  logic vp_r, vs_r, vq_r;
  logic adv_p, adv_s, adv_q;

  rsh_tag_t        tag_p_r, tag_s_r, tag_q_r;
  logic [MW-1:0]   hh_r, hl_r, ll_r;
  logic [MW-1:0]   ahch_r, ahcl_r, alch_r, alcl_r;
  logic [PW-1:0]   h2_nxt, ac_nxt, h2_r, ac_r;
  logic            q_ge0_r;

  assign adv_q   = !vq_r || m_ready;
  assign adv_s   = !vs_r || adv_q;
  assign adv_p   = !vp_r || adv_s;
  assign s_ready = adv_p;

  assign m_valid = vq_r;
  assign m_tag   = tag_q_r;
  assign m_q_ge0 = q_ge0_r;

  // recombine the partial products
  assign h2_nxt = {hh_r, ll_r} + (PW'(hl_r) << (HW + 1));
  assign ac_nxt = {ahch_r, alcl_r} + ((PW'(ahcl_r) + PW'(alch_r)) << HW);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= 1'b0;
      vs_r <= 1'b0;
      vq_r <= 1'b0;
    end else begin
      if (adv_p) vp_r <= s_valid;
      if (adv_s) vs_r <= vp_r;
      if (adv_q) vq_r <= vs_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_p) begin
      tag_p_r <= s_tag;
      hh_r    <= s_habs[MW-1:HW] * s_habs[MW-1:HW];
      hl_r    <= s_habs[MW-1:HW] * s_habs[HW-1:0];
      ll_r    <= s_habs[HW-1:0]  * s_habs[HW-1:0];
      ahch_r  <= s_a[MW-1:HW]    * s_c[MW-1:HW];
      ahcl_r  <= s_a[MW-1:HW]    * s_c[HW-1:0];
      alch_r  <= s_a[HW-1:0]     * s_c[MW-1:HW];
      alcl_r  <= s_a[HW-1:0]     * s_c[HW-1:0];
    end
    if (adv_s) begin
      tag_s_r <= tag_p_r;
      h2_r    <= h2_nxt;
      ac_r    <= ac_nxt;
    end
    if (adv_q) begin
      tag_q_r <= tag_s_r;
      q_ge0_r <= (h2_r >= ac_r);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ray_sphere_hit_test.sv -----
// ray against sphere hit test, top level
// Takes one ray request per clock, while in_ray.ready is high, and returns one result per
// ray, in order. The pipeline runs offset subtract, the nine coordinate products, the
// dot-product sums, sign and magnitude extraction, then three stages that square |d.oc|
// and form A*C from half-width partial products and compare them. Each stage holds its
// own valid bit and only waits when the stage after it is full, so bubbles close up
// under backpressure. Sphere center and radius are written through the register port,
// which is always ready; write them only while no ray is in flight. A ray with a zero
// direction reports hit and zero_direction.
`default_nettype none
module ray_sphere_hit_test #(
  parameter int COORD_WIDTH = rsh_pkg::COORD_WIDTH_DEF
) (
  input  wire       clk,
  input  wire       rst_n,
  rsh_ray_if.sink   in_ray,
  rsh_hit_if.source out_hit,
  rsh_cfg_if.sink   cfg_wr
);
  import rsh_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int OW  = W + 1;        // origin minus center
  localparam int AW  = 2 * W + 2;    // d.d
  localparam int HDW = 2 * W + 3;    // d.oc
  localparam int CDW = 2 * W + 4;    // oc.oc - r*r
  localparam int MW  = 2 * W + 4;    // operand width into the discriminant unit

  // configuration registers
  logic signed [W-1:0] cen_x_r, cen_y_r, cen_z_r;
  logic [W-2:0]        rad_r;

  // stage valid bits and advance enables
  logic v1_r, v2_r, v3_r, v4_r;
  logic adv1, adv2, adv3, adv4;
  logic disc_ready;

  // stage 1: offset and direction
  logic signed [OW-1:0] oc_x_r, oc_y_r, oc_z_r;
  logic signed [W-1:0]  d_x_r, d_y_r, d_z_r;
  logic                 zero1_r;

  // stage 2: products
  logic signed [2*W-1:0] dd_x_r, dd_y_r, dd_z_r;
  logic signed [2*W:0]   do_x_r, do_y_r, do_z_r;
  logic signed [2*W+1:0] oo_x_r, oo_y_r, oo_z_r;
  logic [2*W-3:0]        rr_r;
  logic                  zero2_r;

  // stage 3: dot products
  logic signed [AW-1:0]  a_r;
  logic signed [HDW-1:0] h_r;
  logic signed [CDW-1:0] c_r;
  logic                  zero3_r;

  // stage 4: flags and magnitudes
  logic signed [HDW-1:0] h_mag;
  logic                  h_le0, c_le0;
  rsh_tag_t              tag4_r;
  logic [MW-1:0]         habs4_r, a4_r, c4_r;

  // discriminant unit outputs
  rsh_tag_t disc_tag;
  logic     disc_q_ge0;
  logic     disc_valid;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cen_x_r <= '0;
      cen_y_r <= '0;
      cen_z_r <= '0;
      rad_r   <= '0;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.reg_index)
        CFG_CENTER_X: cen_x_r <= $signed(cfg_wr.wdata);
        CFG_CENTER_Y: cen_y_r <= $signed(cfg_wr.wdata);
        CFG_CENTER_Z: cen_z_r <= $signed(cfg_wr.wdata);
        CFG_RADIUS:   rad_r   <= cfg_wr.wdata[W-2:0];
        default: ;
      endcase
    end
  end

  assign adv4 = !v4_r || disc_ready;
  assign adv3 = !v3_r || adv4;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign in_ray.ready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_ray.valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
    end
  end

  assign h_le0 = h_r[HDW-1] || (h_r == '0);
  assign c_le0 = c_r[CDW-1] || (c_r == '0);
  assign h_mag = h_r[HDW-1] ? -h_r : h_r;

  always_ff @(posedge clk) begin
    if (adv1) begin
      oc_x_r  <= OW'(in_ray.origin_x) - OW'(cen_x_r);
      oc_y_r  <= OW'(in_ray.origin_y) - OW'(cen_y_r);
      oc_z_r  <= OW'(in_ray.origin_z) - OW'(cen_z_r);
      d_x_r   <= in_ray.dir_x;
      d_y_r   <= in_ray.dir_y;
      d_z_r   <= in_ray.dir_z;
      zero1_r <= (in_ray.dir_x == '0) && (in_ray.dir_y == '0) && (in_ray.dir_z == '0);
    end
    if (adv2) begin
      dd_x_r  <= d_x_r * d_x_r;
      dd_y_r  <= d_y_r * d_y_r;
      dd_z_r  <= d_z_r * d_z_r;
      do_x_r  <= d_x_r * oc_x_r;
      do_y_r  <= d_y_r * oc_y_r;
      do_z_r  <= d_z_r * oc_z_r;
      oo_x_r  <= oc_x_r * oc_x_r;
      oo_y_r  <= oc_y_r * oc_y_r;
      oo_z_r  <= oc_z_r * oc_z_r;
      rr_r    <= rad_r * rad_r;
      zero2_r <= zero1_r;
    end
    if (adv3) begin
      a_r     <= AW'(dd_x_r) + AW'(dd_y_r) + AW'(dd_z_r);
      h_r     <= HDW'(do_x_r) + HDW'(do_y_r) + HDW'(do_z_r);
      c_r     <= CDW'(oo_x_r) + CDW'(oo_y_r) + CDW'(oo_z_r)
                 - CDW'($signed({1'b0, rr_r}));
      zero3_r <= zero2_r;
    end
    if (adv4) begin
      tag4_r.c_le0    <= c_le0;
      tag4_r.h_le0    <= h_le0;
      tag4_r.zero_dir <= zero3_r;
      habs4_r         <= MW'(h_mag);
      a4_r            <= MW'(a_r);
      // c only matters when positive
      c4_r            <= c_le0 ? '0 : MW'(c_r);
    end
  end

  rsh_disc #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_disc (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (v4_r),
    .s_ready (disc_ready),
    .s_tag   (tag4_r),
    .s_habs  (habs4_r),
    .s_a     (a4_r),
    .s_c     (c4_r),
    .m_valid (disc_valid),
    .m_ready (out_hit.ready),
    .m_tag   (disc_tag),
    .m_q_ge0 (disc_q_ge0)
  );

  assign out_hit.valid          = disc_valid;
  assign out_hit.hit            = disc_tag.c_le0 | (disc_tag.h_le0 & disc_q_ge0);
  assign out_hit.zero_direction = disc_tag.zero_dir;

  // degenerate ray always reports a hit
  a_zero_dir_hits: assert property (@(posedge clk) disable iff (!rst_n)
    out_hit.valid && out_hit.zero_direction |-> out_hit.hit)
    else $error("zero direction result without hit");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_hit.valid)
    else $error("result valid right after reset");

  // input only stalls when every front stage holds a ray
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ray.ready |-> (v1_r && v2_r && v3_r && v4_r))
    else $error("input stalled with a bubble in the pipeline");

endmodule
`default_nettype wire
